/* hdl/clpc_pkg.sv */
// shared types and constants of the circumsphere lattice point counter
// no dependencies
`timescale 1ns / 1ps
package clpc_pkg;
    localparam int VW      = 48;  // signed setup values: adjugate, determinant, centre
    localparam int WW      = 96;  // squared distances and products
    localparam int CFG_W   = 9;
    localparam int COORD_W = 8;
    localparam int EXTRA_W = 16;
    localparam int STEP_W  = 6;

    localparam logic [CFG_W-1:0]  GRID_RESET   = 9'd16;
    localparam int                GIVEN_POINTS = 4;
    // last microcode steps of the two setup phases
    localparam logic [STEP_W-1:0] STEP_LAST_A  = 6'd44;
    localparam logic [STEP_W-1:0] STEP_LAST_B  = 6'd59;

    typedef logic signed [VW-1:0] t_val;
    typedef logic signed [WW-1:0] t_wide;

    typedef enum logic [1:0] {
        MAC_LOAD,
        MAC_ADD,
        MAC_SUB
    } t_mac_op;

    typedef struct packed {
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] az;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        logic [COORD_W-1:0] bz;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cz;
        logic [COORD_W-1:0] dx_coord;
        logic [COORD_W-1:0] dy_coord;
        logic [COORD_W-1:0] dz_coord;
    } t_item;

    typedef struct packed {
        logic               coplanar;
        logic [EXTRA_W-1:0] extra_points;
        logic               small_denominator;
    } t_result;

    typedef struct packed {
        logic [CFG_W-1:0] grid_size;
    } t_cfg;
endpackage

/* hdl/clpc_chan_if.sv */
// valid/ready channel carrying one payload item
// payload type is a parameter, usually from clpc_pkg
`timescale 1ns / 1ps
interface clpc_chan_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/clpc_mac.sv */
// serial signed multiply-accumulate unit, one multiplier bit per cycle
// depends on clpc_pkg
`timescale 1ns / 1ps
module clpc_mac (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  clpc_pkg::t_val    i_a,
    input  clpc_pkg::t_val    i_b,
    input  clpc_pkg::t_mac_op i_op,
    output logic              o_done,
    output clpc_pkg::t_wide   o_acc
);
    import clpc_pkg::*;

    localparam int               CNT_W    = $clog2(VW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VW - 1);

    logic             r_busy;
    logic             r_done;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic [VW-1:0]    r_mcand;
    logic [VW-1:0]    r_hi;
    logic [VW-1:0]    r_lo;
    t_mac_op          r_op;
    t_wide            r_acc;

    logic [VW-1:0]    w_mag_a;
    logic [VW-1:0]    w_mag_b;
    logic [VW:0]      w_sum;
    logic [2*VW-1:0]  w_prod;
    t_wide            w_term;
    t_wide            w_base;

    always_comb begin
        w_mag_a = i_a[VW-1] ? $unsigned(-i_a) : $unsigned(i_a);
        w_mag_b = i_b[VW-1] ? $unsigned(-i_b) : $unsigned(i_b);
        w_sum   = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : '0);
        w_prod  = {w_sum, r_lo[VW-1:1]};
        w_term  = (r_neg ^ (r_op == MAC_SUB)) ? -t_wide'(w_prod) : t_wide'(w_prod);
        w_base  = (r_op == MAC_LOAD) ? '0 : r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_mcand <= w_mag_a;
                r_lo    <= w_mag_b;
                r_hi    <= '0;
                r_neg   <= i_a[VW-1] ^ i_b[VW-1];
                r_op    <= i_op;
                r_cnt   <= '0;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_hi  <= w_sum[VW:1];
                r_lo  <= {w_sum[0], r_lo[VW-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_acc  <= w_base + w_term;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;
endmodule

/* hdl/clpc_isqrt.sv */
// iterative integer square root, two radicand bits per cycle
// no package dependencies
`timescale 1ns / 1ps
module clpc_isqrt #(
    parameter int W = 96
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_arg,
    output logic           o_done,
    output logic [W/2-1:0] o_root,
    output logic           o_exact
);
    logic         r_busy;
    logic         r_done;
    logic [W-1:0] r_op;
    logic [W-1:0] r_res;
    logic [W-1:0] r_one;
    logic [W-1:0] w_trial;

    assign w_trial = r_res + r_one;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_op   <= i_arg;
                r_res  <= '0;
                r_one  <= W'(1) << (W - 2);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_op >= w_trial) begin
                    r_op  <= r_op - w_trial;
                    r_res <= (r_res >> 1) + r_one;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_one <= r_one >> 2;
                if (r_one[0]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_root  = r_res[W/2-1:0];
    assign o_exact = (r_op == '0);
endmodule

/* hdl/clpc_divchk.sv */
// restoring divisibility check of a bounded numerator, one quotient bit per cycle
// depends on clpc_pkg
`timescale 1ns / 1ps
module clpc_divchk #(
    parameter int QB = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [clpc_pkg::VW-1:0] i_num,
    input  logic [clpc_pkg::VW-1:0] i_det,
    output logic                   o_done,
    output logic                   o_zero
);
    import clpc_pkg::*;

    localparam int               CNT_W    = $clog2(QB + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QB - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [VW-1:0]    r_rem;
    logic [VW+QB-1:0] r_dsh;
    logic             w_ge;

    assign w_ge = {{QB{1'b0}}, r_rem} >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_num;
                r_dsh  <= {{QB{1'b0}}, i_det} << (QB - 1);
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh[VW-1:0];
                end
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_zero = (r_rem == '0);
endmodule

/* hdl/circumsphere_lattice_point_counter.sv */
// top level: setup microsequencer, grid column scan and result register
// depends on clpc_pkg, clpc_chan_if, clpc_mac, clpc_isqrt, clpc_divchk
`timescale 1ns / 1ps
// counts the points of an n x n x n grid that lie on the sphere through four input
// points, with exact integer arithmetic. one item at a time: i_item.ready is high only
// when the block is idle, and the finished result sits in an output register until
// taken. setup runs 60 multiply-accumulate steps on one serial multiplier, each a
// start, one shift-add per multiplier bit, and a done. the scan then visits each x row
// and, in rows whose remainder is nonnegative, each (x, y) column; a square root is
// taken for each column whose remainder is nonnegative, the z roots of an exact square
// root are tested, and a root in range gets a divisibility check. a coplanar quadruple
// ends after setup phase one (45 steps). the grid_size register may be written only
// while idle
module circumsphere_lattice_point_counter #(
    parameter int MAX_GRID = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clpc_chan_if.sink   i_item,
    clpc_chan_if.source o_result,
    clpc_chan_if.sink   i_cfg
);
    import clpc_pkg::*;

    localparam int NW  = $clog2(MAX_GRID + 1);        // grid counter width
    localparam int QB  = $clog2(MAX_GRID);            // quotient bits of z
    localparam int CW  = (NW > CFG_W) ? NW : CFG_W;
    localparam int FW0 = $clog2(2 * MAX_GRID * MAX_GRID + 1);
    localparam int FW  = (FW0 > EXTRA_W + 1) ? FW0 : EXTRA_W + 1;
    localparam logic [CW-1:0] MAX_G = CW'(MAX_GRID);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_CHECK,
        ST_SCAN_X,
        ST_SCAN_Y,
        ST_SQRT,
        ST_ROOT,
        ST_DIV,
        ST_FINISH
    } t_state;

    // destination of an accumulated setup value
    typedef enum logic [4:0] {
        D_NONE, D_A2, D_RHS0, D_RHS1, D_RHS2,
        D_ADJ00, D_ADJ01, D_ADJ02, D_ADJ10, D_ADJ11, D_ADJ12, D_ADJ20, D_ADJ21, D_ADJ22,
        D_DET, D_U0, D_U1, D_U2,
        D_DET2, D_DU0, D_DU1, D_DN, D_E0, D_E1, D_E2, D_T, D_U0SQ, D_U1SQ
    } t_dst;

    typedef struct packed {
        t_val    a;
        t_val    b;
        t_mac_op op;
        t_dst    dst;
    } t_uop;

    function automatic t_uop uop(t_val a, t_val b, t_mac_op op, t_dst dst);
        t_uop u;
        u.a   = a;
        u.b   = b;
        u.op  = op;
        u.dst = dst;
        return u;
    endfunction

    // state and registered outputs
    t_state              r_state;
    logic [STEP_W-1:0]   r_step;
    logic                r_mac_start;
    logic                r_sq_start;
    logic                r_div_start;
    logic [CFG_W-1:0]    r_grid;
    logic                r_out_valid;
    t_result             r_out;

    // item and setup values
    logic [COORD_W-1:0]  r_pt [4][3];
    t_val                r_a2;
    t_val                r_rhs [3];
    t_val                r_adj [3][3];
    t_val                r_det;
    t_val                r_u [3];
    t_val                r_e [3];
    t_wide               r_det2;
    t_wide               r_du0;
    t_wide               r_du1;
    t_wide               r_dn;
    t_wide               r_t;
    t_wide               r_u0sq;
    t_wide               r_u1sq;

    // scan state
    logic [NW-1:0]       r_x;
    logic [NW-1:0]       r_y;
    t_wide               r_sqx;
    t_wide               r_ix;
    t_wide               r_sqy;
    t_wide               r_iy;
    t_wide               r_rx;
    logic [WW-1:0]       r_sq_arg;
    logic [WW/2-1:0]     r_root;
    logic                r_k;
    logic [VW-1:0]       r_div_arg;
    logic [FW-1:0]       r_found;

    // combinational
    t_val                w_p [4][3];
    t_val                w_m [3][3];
    t_uop                w_uop;
    t_val                w_one;
    t_val                w_nv;
    logic [CW-1:0]       w_grid_ext;
    logic [NW-1:0]       w_n;
    logic                w_mac_done;
    t_wide               w_acc;
    t_val                w_accv;
    logic                w_sq_done;
    logic [WW/2-1:0]     w_root;
    logic                w_sq_exact;
    logic                w_div_done;
    logic                w_div_zero;
    t_wide               w_rx;
    t_wide               w_r;
    t_wide               w_two_det2;
    logic signed [VW:0]  w_num;
    t_wide               w_num_wide;
    logic                w_in_range;
    logic [FW-1:0]       w_diff;
    logic [EXTRA_W-1:0]  w_extra;
    t_val                w_two_n;

    // effective grid edge, saturated to MAX_GRID
    assign w_grid_ext = CW'(r_grid);
    assign w_n        = NW'((w_grid_ext > MAX_G) ? MAX_G : w_grid_ext);
    assign w_nv       = t_val'({{(VW-NW){1'b0}}, w_n});
    assign w_two_n    = t_val'({{(VW-NW-1){1'b0}}, w_n, 1'b0});
    assign w_one      = t_val'(1);
    assign w_accv     = t_val'(w_acc[VW-1:0]);

    always_comb begin
        logic signed [COORD_W+1:0] d;
        d = '0;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_p[i][j] = t_val'({{(VW-COORD_W){1'b0}}, r_pt[i][j]});
            end
        end
        // rows of the system: twice the offsets of B, C, D from A
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                d = {2'b00, r_pt[i+1][j]} - {2'b00, r_pt[0][j]};
                w_m[i][j] = t_val'({{(VW-COORD_W-3){d[COORD_W+1]}}, d, 1'b0});
            end
        end
    end

    // setup microcode: each step is one multiply-accumulate on the shared unit
    always_comb begin
        unique case (r_step)
            // |A|^2 and rhs_i = |P_i|^2 - |A|^2
            6'd0:  w_uop = uop(w_p[0][0], w_p[0][0], MAC_LOAD, D_NONE);
            6'd1:  w_uop = uop(w_p[0][1], w_p[0][1], MAC_ADD,  D_NONE);
            6'd2:  w_uop = uop(w_p[0][2], w_p[0][2], MAC_ADD,  D_A2);
            6'd3:  w_uop = uop(w_p[1][0], w_p[1][0], MAC_LOAD, D_NONE);
            6'd4:  w_uop = uop(w_p[1][1], w_p[1][1], MAC_ADD,  D_NONE);
            6'd5:  w_uop = uop(w_p[1][2], w_p[1][2], MAC_ADD,  D_NONE);
            6'd6:  w_uop = uop(r_a2,      w_one,     MAC_SUB,  D_RHS0);
            6'd7:  w_uop = uop(w_p[2][0], w_p[2][0], MAC_LOAD, D_NONE);
            6'd8:  w_uop = uop(w_p[2][1], w_p[2][1], MAC_ADD,  D_NONE);
            6'd9:  w_uop = uop(w_p[2][2], w_p[2][2], MAC_ADD,  D_NONE);
            6'd10: w_uop = uop(r_a2,      w_one,     MAC_SUB,  D_RHS1);
            6'd11: w_uop = uop(w_p[3][0], w_p[3][0], MAC_LOAD, D_NONE);
            6'd12: w_uop = uop(w_p[3][1], w_p[3][1], MAC_ADD,  D_NONE);
            6'd13: w_uop = uop(w_p[3][2], w_p[3][2], MAC_ADD,  D_NONE);
            6'd14: w_uop = uop(r_a2,      w_one,     MAC_SUB,  D_RHS2);
            // adjugate
            6'd15: w_uop = uop(w_m[1][1], w_m[2][2], MAC_LOAD, D_NONE);
            6'd16: w_uop = uop(w_m[1][2], w_m[2][1], MAC_SUB,  D_ADJ00);
            6'd17: w_uop = uop(w_m[0][2], w_m[2][1], MAC_LOAD, D_NONE);
            6'd18: w_uop = uop(w_m[0][1], w_m[2][2], MAC_SUB,  D_ADJ01);
            6'd19: w_uop = uop(w_m[0][1], w_m[1][2], MAC_LOAD, D_NONE);
            6'd20: w_uop = uop(w_m[0][2], w_m[1][1], MAC_SUB,  D_ADJ02);
            6'd21: w_uop = uop(w_m[1][2], w_m[2][0], MAC_LOAD, D_NONE);
            6'd22: w_uop = uop(w_m[1][0], w_m[2][2], MAC_SUB,  D_ADJ10);
            6'd23: w_uop = uop(w_m[0][0], w_m[2][2], MAC_LOAD, D_NONE);
            6'd24: w_uop = uop(w_m[0][2], w_m[2][0], MAC_SUB,  D_ADJ11);
            6'd25: w_uop = uop(w_m[0][2], w_m[1][0], MAC_LOAD, D_NONE);
            6'd26: w_uop = uop(w_m[0][0], w_m[1][2], MAC_SUB,  D_ADJ12);
            6'd27: w_uop = uop(w_m[1][0], w_m[2][1], MAC_LOAD, D_NONE);
            6'd28: w_uop = uop(w_m[1][1], w_m[2][0], MAC_SUB,  D_ADJ20);
            6'd29: w_uop = uop(w_m[0][1], w_m[2][0], MAC_LOAD, D_NONE);
            6'd30: w_uop = uop(w_m[0][0], w_m[2][1], MAC_SUB,  D_ADJ21);
            6'd31: w_uop = uop(w_m[0][0], w_m[1][1], MAC_LOAD, D_NONE);
            6'd32: w_uop = uop(w_m[0][1], w_m[1][0], MAC_SUB,  D_ADJ22);
            // determinant, expanded down the first column of the adjugate
            6'd33: w_uop = uop(w_m[0][0], r_adj[0][0], MAC_LOAD, D_NONE);
            6'd34: w_uop = uop(w_m[0][1], r_adj[1][0], MAC_ADD,  D_NONE);
            6'd35: w_uop = uop(w_m[0][2], r_adj[2][0], MAC_ADD,  D_DET);
            // scaled centre u = adj * rhs
            6'd36: w_uop = uop(r_adj[0][0], r_rhs[0], MAC_LOAD, D_NONE);
            6'd37: w_uop = uop(r_adj[0][1], r_rhs[1], MAC_ADD,  D_NONE);
            6'd38: w_uop = uop(r_adj[0][2], r_rhs[2], MAC_ADD,  D_U0);
            6'd39: w_uop = uop(r_adj[1][0], r_rhs[0], MAC_LOAD, D_NONE);
            6'd40: w_uop = uop(r_adj[1][1], r_rhs[1], MAC_ADD,  D_NONE);
            6'd41: w_uop = uop(r_adj[1][2], r_rhs[2], MAC_ADD,  D_U1);
            6'd42: w_uop = uop(r_adj[2][0], r_rhs[0], MAC_LOAD, D_NONE);
            6'd43: w_uop = uop(r_adj[2][1], r_rhs[1], MAC_ADD,  D_NONE);
            6'd44: w_uop = uop(r_adj[2][2], r_rhs[2], MAC_ADD,  D_U2);
            // after sign normalization: scan increments, range bound, radius
            6'd45: w_uop = uop(r_det,  r_det,     MAC_LOAD, D_DET2);
            6'd46: w_uop = uop(r_det,  r_u[0],    MAC_LOAD, D_DU0);
            6'd47: w_uop = uop(r_det,  r_u[1],    MAC_LOAD, D_DU1);
            6'd48: w_uop = uop(r_det,  w_nv,      MAC_LOAD, D_DN);
            6'd49: w_uop = uop(r_det,  w_p[0][0], MAC_LOAD, D_NONE);
            6'd50: w_uop = uop(r_u[0], w_one,     MAC_SUB,  D_E0);
            6'd51: w_uop = uop(r_det,  w_p[0][1], MAC_LOAD, D_NONE);
            6'd52: w_uop = uop(r_u[1], w_one,     MAC_SUB,  D_E1);
            6'd53: w_uop = uop(r_det,  w_p[0][2], MAC_LOAD, D_NONE);
            6'd54: w_uop = uop(r_u[2], w_one,     MAC_SUB,  D_E2);
            6'd55: w_uop = uop(r_e[0], r_e[0],    MAC_LOAD, D_NONE);
            6'd56: w_uop = uop(r_e[1], r_e[1],    MAC_ADD,  D_NONE);
            6'd57: w_uop = uop(r_e[2], r_e[2],    MAC_ADD,  D_T);
            6'd58: w_uop = uop(r_u[0], r_u[0],    MAC_LOAD, D_U0SQ);
            6'd59: w_uop = uop(r_u[1], r_u[1],    MAC_LOAD, D_U1SQ);
            default: w_uop = uop('0, '0, MAC_LOAD, D_NONE);
        endcase
    end

    // column remainders and z candidates
    always_comb begin
        w_rx       = r_t - r_sqx;
        w_r        = r_rx - r_sqy;
        w_two_det2 = r_det2 <<< 1;
        w_num      = r_k ? ({r_u[2][VW-1], r_u[2]} + $signed({1'b0, r_root}))
                         : ({r_u[2][VW-1], r_u[2]} - $signed({1'b0, r_root}));
        w_num_wide = t_wide'({{(WW-VW-1){w_num[VW]}}, w_num});
        w_in_range = !w_num[VW] && (w_num_wide < r_dn);
        // the four given points are part of the count
        w_diff     = r_found - FW'(GIVEN_POINTS);
        if (r_found < FW'(GIVEN_POINTS)) begin
            w_extra = '0;
        end else if (w_diff > FW'({EXTRA_W{1'b1}})) begin
            w_extra = {EXTRA_W{1'b1}};
        end else begin
            w_extra = w_diff[EXTRA_W-1:0];
        end
    end

    clpc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mac_start),
        .i_a     (w_uop.a),
        .i_b     (w_uop.b),
        .i_op    (w_uop.op),
        .o_done  (w_mac_done),
        .o_acc   (w_acc)
    );

    clpc_isqrt #(.W(WW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_start),
        .i_arg   (r_sq_arg),
        .o_done  (w_sq_done),
        .o_root  (w_root),
        .o_exact (w_sq_exact)
    );

    clpc_divchk #(.QB(QB)) u_divchk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_arg),
        .i_det   ($unsigned(r_det)),
        .o_done  (w_div_done),
        .o_zero  (w_div_zero)
    );

    assign i_item.ready     = (r_state == ST_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_mac_start <= 1'b0;
            r_sq_start  <= 1'b0;
            r_div_start <= 1'b0;
            r_grid      <= GRID_RESET;
            r_out_valid <= 1'b0;
            r_found     <= '0;
        end else begin
            r_mac_start <= 1'b0;
            r_sq_start  <= 1'b0;
            r_div_start <= 1'b0;

            if (i_cfg.valid) begin
                r_grid <= i_cfg.payload.grid_size;
            end
            // result register: loaded at the end of an item, emptied when taken
            if (r_state == ST_FINISH && (!r_out_valid || o_result.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_item.valid) begin
                        r_pt[0][0]  <= i_item.payload.ax;
                        r_pt[0][1]  <= i_item.payload.ay;
                        r_pt[0][2]  <= i_item.payload.az;
                        r_pt[1][0]  <= i_item.payload.bx;
                        r_pt[1][1]  <= i_item.payload.by;
                        r_pt[1][2]  <= i_item.payload.bz;
                        r_pt[2][0]  <= i_item.payload.cx;
                        r_pt[2][1]  <= i_item.payload.cy;
                        r_pt[2][2]  <= i_item.payload.cz;
                        r_pt[3][0]  <= i_item.payload.dx_coord;
                        r_pt[3][1]  <= i_item.payload.dy_coord;
                        r_pt[3][2]  <= i_item.payload.dz_coord;
                        r_step      <= '0;
                        r_found     <= '0;
                        r_mac_start <= 1'b1;
                        r_state     <= ST_MAC;
                    end
                end

                ST_MAC: begin
                    if (w_mac_done) begin
                        unique case (w_uop.dst)
                            D_NONE:  ;
                            D_A2:    r_a2        <= w_accv;
                            D_RHS0:  r_rhs[0]    <= w_accv;
                            D_RHS1:  r_rhs[1]    <= w_accv;
                            D_RHS2:  r_rhs[2]    <= w_accv;
                            D_ADJ00: r_adj[0][0] <= w_accv;
                            D_ADJ01: r_adj[0][1] <= w_accv;
                            D_ADJ02: r_adj[0][2] <= w_accv;
                            D_ADJ10: r_adj[1][0] <= w_accv;
                            D_ADJ11: r_adj[1][1] <= w_accv;
                            D_ADJ12: r_adj[1][2] <= w_accv;
                            D_ADJ20: r_adj[2][0] <= w_accv;
                            D_ADJ21: r_adj[2][1] <= w_accv;
                            D_ADJ22: r_adj[2][2] <= w_accv;
                            D_DET:   r_det       <= w_accv;
                            D_U0:    r_u[0]      <= w_accv;
                            D_U1:    r_u[1]      <= w_accv;
                            D_U2:    r_u[2]      <= w_accv;
                            D_DET2:  r_det2      <= w_acc;
                            D_DU0:   r_du0       <= w_acc;
                            D_DU1:   r_du1       <= w_acc;
                            D_DN:    r_dn        <= w_acc;
                            D_E0:    r_e[0]      <= w_accv;
                            D_E1:    r_e[1]      <= w_accv;
                            D_E2:    r_e[2]      <= w_accv;
                            D_T:     r_t         <= w_acc;
                            D_U0SQ:  r_u0sq      <= w_acc;
                            D_U1SQ:  r_u1sq      <= w_acc;
                            default: ;
                        endcase
                        if (r_step == STEP_LAST_A) begin
                            r_state <= ST_CHECK;
                        end else if (r_step == STEP_LAST_B) begin
                            // x = 0: dx = -u0, increment (dx+det)^2 - dx^2
                            r_x     <= '0;
                            r_sqx   <= r_u0sq;
                            r_ix    <= r_det2 - (r_du0 <<< 1);
                            r_state <= ST_SCAN_X;
                        end else begin
                            r_step      <= r_step + 1'b1;
                            r_mac_start <= 1'b1;
                        end
                    end
                end

                ST_CHECK: begin
                    if (r_det == '0) begin
                        r_state <= ST_FINISH;
                    end else begin
                        // keep det positive, flip the centre with it
                        if (r_det[VW-1]) begin
                            r_det  <= -r_det;
                            r_u[0] <= -r_u[0];
                            r_u[1] <= -r_u[1];
                            r_u[2] <= -r_u[2];
                        end
                        r_step      <= STEP_LAST_A + 1'b1;
                        r_mac_start <= 1'b1;
                        r_state     <= ST_MAC;
                    end
                end

                ST_SCAN_X: begin
                    if (r_x == w_n) begin
                        r_state <= ST_FINISH;
                    end else if (w_rx[WW-1]) begin
                        r_x   <= r_x + 1'b1;
                        r_sqx <= r_sqx + r_ix;
                        r_ix  <= r_ix + w_two_det2;
                    end else begin
                        r_rx    <= w_rx;
                        r_y     <= '0;
                        r_sqy   <= r_u1sq;
                        r_iy    <= r_det2 - (r_du1 <<< 1);
                        r_state <= ST_SCAN_Y;
                    end
                end

                ST_SCAN_Y: begin
                    if (r_y == w_n) begin
                        r_x     <= r_x + 1'b1;
                        r_sqx   <= r_sqx + r_ix;
                        r_ix    <= r_ix + w_two_det2;
                        r_state <= ST_SCAN_X;
                    end else begin
                        r_y   <= r_y + 1'b1;
                        r_sqy <= r_sqy + r_iy;
                        r_iy  <= r_iy + w_two_det2;
                        if (!w_r[WW-1]) begin
                            r_sq_arg   <= $unsigned(w_r);
                            r_sq_start <= 1'b1;
                            r_state    <= ST_SQRT;
                        end
                    end
                end

                ST_SQRT: begin
                    if (w_sq_done) begin
                        if (w_sq_exact) begin
                            r_root  <= w_root;
                            r_k     <= 1'b0;
                            r_state <= ST_ROOT;
                        end else begin
                            r_state <= ST_SCAN_Y;
                        end
                    end
                end

                ST_ROOT: begin
                    if (w_in_range) begin
                        r_div_arg   <= w_num[VW-1:0];
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIV;
                    end else if (!r_k && r_root != '0) begin
                        r_k <= 1'b1;
                    end else begin
                        r_state <= ST_SCAN_Y;
                    end
                end

                ST_DIV: begin
                    if (w_div_done) begin
                        if (w_div_zero) begin
                            r_found <= r_found + 1'b1;
                        end
                        // second root only when the root is nonzero
                        if (!r_k && r_root != '0) begin
                            r_k     <= 1'b1;
                            r_state <= ST_ROOT;
                        end else begin
                            r_state <= ST_SCAN_Y;
                        end
                    end
                end

                ST_FINISH: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_out.coplanar            <= (r_det == '0);
                        r_out.extra_points        <= w_extra;
                        r_out.small_denominator   <= (r_det <= w_two_n);
                        r_state                   <= ST_IDLE;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // a coplanar result always carries a zero count and the small flag
    a_coplanar_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.payload.coplanar) |->
            (o_result.payload.extra_points == '0 && o_result.payload.small_denominator))
        else $error("coplanar result with nonzero count or clear small flag");

    // the multiplier is only started by the setup sequencer
    a_mac_start_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mac_start |-> (r_state == ST_MAC))
        else $error("multiplier started outside setup");

    // the point count never falls while an item is in work
    a_found_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |=> (r_found >= $past(r_found)))
        else $error("point count decreased during scan");
endmodule
